### src/shapad_pkg.sv
// shared types and constants of the sha-256 message padder
`timescale 1ns / 1ps

package shapad_pkg;

  // kind of an input beat after classification
  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_END  = 1'b1
  } kind_t;

  // one classified input beat as it sits in the queue
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } item_t;

  // head of the queue as the back end sees it
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    ST_BYTES  = 3'd0,
    ST_MARK   = 3'd1,
    ST_ZERO   = 3'd2,
    ST_LEN_HI = 3'd3,
    ST_LEN_LO = 3'd4
  } state_t;

  localparam logic [7:0] PAD_MARK      = 8'h80;
  localparam logic [3:0] LEN_WORD_POS  = 4'd14;
  localparam logic [3:0] LAST_WORD_POS = 4'd15;
  localparam logic [1:0] LAST_BYTE_POS = 2'd3;
  localparam logic [1:0] QUEUE_DEPTH   = 2'd2;

endpackage

### src/shapad_front.sv
// input side: beat classification and a two-entry queue toward the back end
`timescale 1ns / 1ps

module shapad_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                action,
  input  logic [7:0]          data_byte,
  input  logic                take,
  output shapad_pkg::q_head_t head
);

  shapad_pkg::item_t slots [2];
  shapad_pkg::item_t in_item;
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              push;
  logic              pop;

  always_comb begin
    in_item.kind = action ? shapad_pkg::KIND_END : shapad_pkg::KIND_BYTE;
    in_item.data = data_byte;
  end

  assign in_ready   = (count != shapad_pkg::QUEUE_DEPTH);
  assign push       = in_valid && in_ready;
  assign head.valid = (count != 2'd0);
  assign head.item  = slots[rd_ptr];
  assign pop        = take && head.valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

### src/shapad_back.sv
// output side: word packing, padding sequencer and output register
`timescale 1ns / 1ps

module shapad_back #(
  parameter int LENGTH_COUNTER_BITS = 61
) (
  input  logic                clk,
  input  logic                rst,
  input  shapad_pkg::q_head_t head,
  output logic                take,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         word,
  output logic                block_last,
  output logic                message_last
);

  shapad_pkg::state_t             state;
  shapad_pkg::state_t             state_next;
  logic [LENGTH_COUNTER_BITS-1:0] byte_count;
  logic [23:0]                    partial_word;
  logic [1:0]                     bytes_in_word;
  logic [3:0]                     words_in_block;

  logic        out_free;
  logic        head_is_byte;
  logic        emit;
  logic [31:0] emit_word;
  logic        emit_msg_last;
  logic [31:0] mark_word;
  logic [63:0] bit_len;
  logic        len_next;

  assign out_free     = !out_valid || out_ready;
  assign head_is_byte = (head.item.kind == shapad_pkg::KIND_BYTE);
  assign bit_len      = 64'(byte_count) << 3;
  assign len_next     = (words_in_block == shapad_pkg::LEN_WORD_POS - 4'd1);

  // pending bytes, then the 0x80 marker, left aligned
  always_comb begin
    case (bytes_in_word)
      2'd0:    mark_word = {shapad_pkg::PAD_MARK, 24'h0};
      2'd1:    mark_word = {partial_word[7:0], shapad_pkg::PAD_MARK, 16'h0};
      2'd2:    mark_word = {partial_word[15:0], shapad_pkg::PAD_MARK, 8'h0};
      default: mark_word = {partial_word, shapad_pkg::PAD_MARK};
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      shapad_pkg::ST_BYTES: begin
        if (take && !head_is_byte) begin
          state_next = shapad_pkg::ST_MARK;
        end
      end
      shapad_pkg::ST_MARK, shapad_pkg::ST_ZERO: begin
        if (out_free) begin
          state_next = len_next ? shapad_pkg::ST_LEN_HI : shapad_pkg::ST_ZERO;
        end
      end
      shapad_pkg::ST_LEN_HI: begin
        if (out_free) begin
          state_next = shapad_pkg::ST_LEN_LO;
        end
      end
      shapad_pkg::ST_LEN_LO: begin
        if (out_free) begin
          state_next = shapad_pkg::ST_BYTES;
        end
      end
      default: state_next = shapad_pkg::ST_BYTES;
    endcase
  end

  always_comb begin
    take          = 1'b0;
    emit          = 1'b0;
    emit_word     = '0;
    emit_msg_last = 1'b0;
    case (state)
      shapad_pkg::ST_BYTES: begin
        if (head.valid) begin
          if (!head_is_byte) begin
            take = 1'b1;
          end else if (bytes_in_word != shapad_pkg::LAST_BYTE_POS || out_free) begin
            take      = 1'b1;
            emit      = (bytes_in_word == shapad_pkg::LAST_BYTE_POS);
            emit_word = {partial_word, head.item.data};
          end
        end
      end
      shapad_pkg::ST_MARK: begin
        emit      = out_free;
        emit_word = mark_word;
      end
      shapad_pkg::ST_ZERO: begin
        emit = out_free;
      end
      shapad_pkg::ST_LEN_HI: begin
        emit      = out_free;
        emit_word = bit_len[63:32];
      end
      shapad_pkg::ST_LEN_LO: begin
        emit          = out_free;
        emit_word     = bit_len[31:0];
        emit_msg_last = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= shapad_pkg::ST_BYTES;
      byte_count     <= '0;
      partial_word   <= '0;
      bytes_in_word  <= '0;
      words_in_block <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (take && head_is_byte) begin
        byte_count    <= byte_count + LENGTH_COUNTER_BITS'(1);
        bytes_in_word <= bytes_in_word + 2'd1;
        if (bytes_in_word == shapad_pkg::LAST_BYTE_POS) begin
          partial_word <= '0;
        end else begin
          partial_word <= {partial_word[15:0], head.item.data};
        end
      end
      if (state == shapad_pkg::ST_MARK && emit) begin
        bytes_in_word <= '0;
        partial_word  <= '0;
      end
      if (emit) begin
        words_in_block <= words_in_block + 4'd1;
      end
      if (state == shapad_pkg::ST_LEN_LO && emit) begin
        byte_count <= '0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      word         <= emit_word;
      block_last   <= (words_in_block == shapad_pkg::LAST_WORD_POS);
      message_last <= emit_msg_last;
    end
  end

endmodule

### src/sha256_message_padder.sv
// top level of the sha-256 message padder
`timescale 1ns / 1ps

// channel | handshake           | payload
// --------+---------------------+------------------------------------
// in      | in_valid / in_ready | action, data_byte
// out     | out_valid/out_ready | word, block_last, message_last
//
// a word leaves on every fourth byte
// an end beat is taken first; then 3 to 18 padding words follow at
// one per cycle while the output is free, from the padding sequencer,
// which holds the queue head until the message closes
// the two-entry input queue accepts up to two beats while the sequencer runs
// rst is synchronous; after it the block takes a beat in the next cycle

module sha256_message_padder #(
  parameter int LENGTH_COUNTER_BITS = 61
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] word,
  output logic        block_last,
  output logic        message_last
);

  // queue head and the pop strobe between the two halves
  shapad_pkg::q_head_t head;
  logic                take;

  // front: classifies each beat and queues it
  shapad_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .data_byte (data_byte),
    .take      (take),
    .head      (head)
  );

  // back: packs bytes into words and runs the padding sequence
  shapad_back #(
    .LENGTH_COUNTER_BITS (LENGTH_COUNTER_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .take         (take),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .word         (word),
    .block_last   (block_last),
    .message_last (message_last)
  );

endmodule
